[hw/rtl/hiwa_pkg.sv]
// ----------------------------------------------------------------------------
// hiwa_pkg
// Types, constants and helpers of the homography inverse warp address block.
// ----------------------------------------------------------------------------
package hiwa_pkg;

  localparam int unsigned COEF_W   = 48;
  localparam int unsigned COORD_W  = 12;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned ACC_W    = 64;
  localparam int unsigned MAG_W    = 63;
  localparam int unsigned REM_W    = MAG_W + COORD_W;
  localparam int unsigned DIV_STAGES = COORD_W;

  localparam int unsigned SRC_WIDTH  = 4096;
  localparam int unsigned SRC_HEIGHT = 4096;

  localparam logic signed [ACC_W-1:0] ONE_Q32 = ACC_W'(64'sd4294967296);
  localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(64'd4294967296);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_M00 = 3'd0,
    REG_M01 = 3'd1,
    REG_M02 = 3'd2,
    REG_M10 = 3'd3,
    REG_M11 = 3'd4,
    REG_M12 = 3'd5,
    REG_M20 = 3'd6,
    REG_M21 = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [COORD_W-1:0] dest_x;
    logic [COORD_W-1:0] dest_y;
  } in_beat_t;

  typedef struct packed {
    logic [COORD_W-1:0] src_x;
    logic [COORD_W-1:0] src_y;
    logic               inside_res;
  } out_beat_t;

  typedef struct packed {
    logic               v;
    logic               ok_x;
    logic               ok_y;
    logic [REM_W-1:0]   rx;
    logic [REM_W-1:0]   ry;
    logic [MAG_W-1:0]   dw;
    logic [COORD_W-1:0] qx;
    logic [COORD_W-1:0] qy;
  } div_t;

  function automatic div_t div_step(div_t d, int unsigned sh);
    div_t             r;
    logic [REM_W-1:0] dsh;
    r   = d;
    dsh = REM_W'(d.dw) << sh;
    if (d.rx >= dsh) begin
      r.rx     = d.rx - dsh;
      r.qx[sh] = 1'b1;
    end
    if (d.ry >= dsh) begin
      r.ry     = d.ry - dsh;
      r.qy[sh] = 1'b1;
    end
    return r;
  endfunction

endpackage

[hw/rtl/homography_inverse_warp_address_top.sv]
// ----------------------------------------------------------------------------
// homography_inverse_warp_address_top
// Maps destination pixel coordinates to source coordinates through a
// 3x3 inverse homography with restoring division, one quotient bit a stage.
// Pipeline: products, sums, sign and range prep, 12 division stages,
// output register.
// Throughput: one beat per cycle; the whole pipe holds while the output
// beat is stalled.
// Reset: matrix returns to identity, all valid bits clear.
// ----------------------------------------------------------------------------
module homography_inverse_warp_address_top
  import hiwa_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [COEF_W-1:0]    cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_beat_t             in_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_beat_t            out_o
);

  logic signed [COEF_W-1:0] m00_q, m01_q, m02_q, m10_q, m11_q, m12_q, m20_q, m21_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m00_q <= COEF_ONE;
      m01_q <= '0;
      m02_q <= '0;
      m10_q <= '0;
      m11_q <= COEF_ONE;
      m12_q <= '0;
      m20_q <= '0;
      m21_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_M00: m00_q <= cfg_data_i;
        REG_M01: m01_q <= cfg_data_i;
        REG_M02: m02_q <= cfg_data_i;
        REG_M10: m10_q <= cfg_data_i;
        REG_M11: m11_q <= cfg_data_i;
        REG_M12: m12_q <= cfg_data_i;
        REG_M20: m20_q <= cfg_data_i;
        REG_M21: m21_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic adv;
  assign adv        = !out_valid_o || !out_stall_i;
  assign in_stall_o = !adv;

  // products
  logic                    p_v_q;
  logic signed [ACC_W-1:0] p00_q, p01_q, p10_q, p11_q, p20_q, p21_q;
  logic signed [ACC_W-1:0] xs, ys;

  assign xs = ACC_W'(signed'({1'b0, in_i.dest_x}));
  assign ys = ACC_W'(signed'({1'b0, in_i.dest_y}));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_v_q <= 1'b0;
    end else if (adv) begin
      p_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p00_q <= ACC_W'(m00_q) * xs;
      p01_q <= ACC_W'(m01_q) * ys;
      p10_q <= ACC_W'(m10_q) * xs;
      p11_q <= ACC_W'(m11_q) * ys;
      p20_q <= ACC_W'(m20_q) * xs;
      p21_q <= ACC_W'(m21_q) * ys;
    end
  end

  // sums
  logic                    s_v_q;
  logic signed [ACC_W-1:0] u_q, v_q, w_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_v_q <= 1'b0;
    end else if (adv) begin
      s_v_q <= p_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      u_q <= p00_q + p01_q + ACC_W'(m02_q);
      v_q <= p10_q + p11_q + ACC_W'(m12_q);
      w_q <= p20_q + p21_q + ONE_Q32;
    end
  end

  // sign and range prep
  logic [ACC_W-1:0] au_full, av_full, aw_full;
  logic [MAG_W-1:0] au, av, aw;
  logic             wnz, big_x, big_y, ok_x, ok_y;
  div_t             prep;

  always_comb begin
    au_full = u_q[ACC_W-1] ? ACC_W'(-u_q) : ACC_W'(u_q);
    av_full = v_q[ACC_W-1] ? ACC_W'(-v_q) : ACC_W'(v_q);
    aw_full = w_q[ACC_W-1] ? ACC_W'(-w_q) : ACC_W'(w_q);
    au      = au_full[MAG_W-1:0];
    av      = av_full[MAG_W-1:0];
    aw      = aw_full[MAG_W-1:0];
    wnz     = (w_q != '0);
    big_x   = (u_q[ACC_W-1] == w_q[ACC_W-1])
              ? (REM_W'(au) >= (REM_W'(aw) << COORD_W)) : (au >= aw);
    big_y   = (v_q[ACC_W-1] == w_q[ACC_W-1])
              ? (REM_W'(av) >= (REM_W'(aw) << COORD_W)) : (av >= aw);
    ok_x    = wnz && !big_x;
    ok_y    = wnz && !big_y;
    prep      = '0;
    prep.v    = s_v_q;
    prep.ok_x = ok_x;
    prep.ok_y = ok_y;
    prep.rx   = REM_W'(au);
    prep.ry   = REM_W'(av);
    prep.dw   = aw;
  end

  div_t div_q [DIV_STAGES+1];
  div_t div_d [DIV_STAGES+1];

  always_comb begin
    div_d[0] = prep;
    for (int unsigned s = 0; s < DIV_STAGES; s++) begin
      div_d[s+1] = div_step(div_q[s], DIV_STAGES - 1 - s);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned s = 0; s <= DIV_STAGES; s++) begin
        div_q[s] <= '0;
      end
    end else if (adv) begin
      for (int unsigned s = 0; s <= DIV_STAGES; s++) begin
        div_q[s] <= div_d[s];
      end
    end
  end

  // output register
  div_t      fin;
  logic      src_ok;
  out_beat_t out_d;
  out_beat_t out_q;
  logic      out_v_q;

  always_comb begin
    fin    = div_q[DIV_STAGES];
    src_ok = fin.ok_x && fin.ok_y
             && ({1'b0, fin.qx} < (COORD_W+1)'(SRC_WIDTH))
             && ({1'b0, fin.qy} < (COORD_W+1)'(SRC_HEIGHT));
    out_d.src_x      = src_ok ? fin.qx : '0;
    out_d.src_y      = src_ok ? fin.qy : '0;
    out_d.inside_res = src_ok;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv) begin
      out_v_q <= fin.v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_o       = out_q;

  a_black_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_o.inside_res |-> out_o.src_x == '0 && out_o.src_y == '0)
    else $error("black pixel with nonzero source");

  a_inside_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.inside_res |->
      {1'b0, out_o.src_x} < (COORD_W+1)'(SRC_WIDTH) &&
      {1'b0, out_o.src_y} < (COORD_W+1)'(SRC_HEIGHT))
    else $error("inside source out of image");

  a_hold_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(p_v_q) && $stable(s_v_q) && $stable(div_q[DIV_STAGES].v))
    else $error("pipeline moved while held");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_o))
    else $error("stalled output beat changed");

endmodule
